// ===== hw/rtl/tpfa_pkg.sv =====
// Shared types and constants for the trinomial fold accumulator.
// No dependencies; used by tpfa_ctrl, tpfa_datapath and the top level.
package tpfa_pkg;

  localparam int unsigned IdxW    = 12;
  localparam int unsigned IdxExtW = 14;  // holds 2*DEGREE-2 for any legal DEGREE
  localparam int unsigned CoefW   = 32;
  localparam int unsigned ResIdxW = 11;
  localparam int unsigned ModW    = 30;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgW    = 30;

  localparam logic [CfgIdxW-1:0] CfgModulus = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgCenter  = 1'b1;

  localparam logic [ModW-1:0] ModulusRst = 30'd134250497;
  localparam logic            CenterRst  = 1'b1;

  localparam logic OpLoad = 1'b0;
  localparam logic OpRead = 1'b1;

  typedef struct packed {
    logic item_load;  // capture the input item
    logic mem_rd;     // read accumulator entry
    logic mem_wr;     // write back accumulator entry
    logic sel_b;      // second entry of a two-entry fold
    logic clr_wr;     // clearing pass write
    logic out_load;   // load the result register
  } cmd_t;

  typedef struct packed {
    logic in_act;    // incoming item touches the store
    logic two;       // captured item folds into two entries
    logic is_read;   // captured item is a read
    logic clr_last;  // last entry of the clearing pass
  } status_t;

endpackage

// ===== hw/rtl/tpfa_ctrl.sv =====
// Sequencer for the fold accumulator: clearing pass, read-modify-write slots,
// result valid and input stall. Depends on tpfa_pkg.
module tpfa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  input  tpfa_pkg::status_t status_i,
  output tpfa_pkg::cmd_t    cmd_o
);

  localparam logic [2:0] SClear = 3'd0;
  localparam logic [2:0] SIdle  = 3'd1;
  localparam logic [2:0] SRdA   = 3'd2;
  localparam logic [2:0] SWrA   = 3'd3;
  localparam logic [2:0] SRdB   = 3'd4;
  localparam logic [2:0] SWrB   = 3'd5;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free, wra_done, can_take, accept;

  assign out_free = !out_valid_q || !out_stall_i;
  // a read holds in its write slot until the result register is free
  assign wra_done = (state_q == SWrA) && (!status_i.is_read || out_free);
  assign can_take = (state_q == SIdle) || (wra_done && !status_i.two) || (state_q == SWrB);
  assign accept   = in_valid_i && can_take;

  always_comb begin
    state_d = state_q;
    case (state_q)
      SClear: if (status_i.clr_last) state_d = SIdle;
      SIdle:  if (accept && status_i.in_act) state_d = SRdA;
      SRdA:   state_d = SWrA;
      SWrA: begin
        if (wra_done) begin
          if (status_i.two) state_d = SRdB;
          else state_d = (accept && status_i.in_act) ? SRdA : SIdle;
        end
      end
      SRdB:   state_d = SWrB;
      SWrB:   state_d = (accept && status_i.in_act) ? SRdA : SIdle;
      default: state_d = SClear;
    endcase
  end

  always_comb begin
    cmd_o.item_load = accept;
    cmd_o.mem_rd    = (state_q == SRdA) || (state_q == SRdB);
    cmd_o.mem_wr    = wra_done || (state_q == SWrB);
    cmd_o.sel_b     = (state_q == SRdB) || (state_q == SWrB);
    cmd_o.clr_wr    = (state_q == SClear);
    cmd_o.out_load  = wra_done && status_i.is_read;
  end

  assign out_valid_d = cmd_o.out_load || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SClear;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = !can_take;
  assign out_valid_o = out_valid_q;

endmodule

// ===== hw/rtl/tpfa_datapath.sv =====
// Datapath: config registers, centering, fold address decode, the
// accumulator memory with its clear counter, and the result register.
// Depends on tpfa_pkg.
module tpfa_datapath #(
  parameter int unsigned DEGREE = 1152
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [tpfa_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [tpfa_pkg::CfgW-1:0]    cfg_data_i,
  input  logic                         opcode_i,
  input  logic [tpfa_pkg::IdxW-1:0]    index_i,
  input  logic [tpfa_pkg::CoefW-1:0]   coefficient_i,
  input  tpfa_pkg::cmd_t               cmd_i,
  output tpfa_pkg::status_t            status_o,
  output logic [tpfa_pkg::CoefW-1:0]   value_o,
  output logic [tpfa_pkg::ResIdxW-1:0] result_index_o
);

  localparam int unsigned AddrW = $clog2(DEGREE);
  localparam int unsigned XW    = tpfa_pkg::IdxExtW;
  localparam logic [XW-1:0] N    = XW'(DEGREE);
  localparam logic [XW-1:0] H    = XW'(DEGREE / 2);
  localparam logic [XW-1:0] NH   = XW'(DEGREE + DEGREE / 2);
  localparam logic [XW-1:0] TopI = XW'(2 * DEGREE - 2);

  logic [tpfa_pkg::ModW-1:0]  modulus_q;
  logic                       center_q;
  logic [tpfa_pkg::CoefW-1:0] mem [DEGREE];
  logic [tpfa_pkg::CoefW-1:0] rdata_q;
  logic [AddrW-1:0]           clr_cnt_q;

  // captured item
  logic                         read_q, two_q, sub_a_q;
  logic [AddrW-1:0]             addr_a_q, addr_b_q;
  logic [tpfa_pkg::CoefW-1:0]   val_q;
  logic [tpfa_pkg::ResIdxW-1:0] ridx_q;

  // decode of the incoming item
  logic [XW-1:0]              ix, a_d, b_d;
  logic                       act_d, two_d, sub_a_d;
  logic [tpfa_pkg::CoefW-1:0] cen_v;

  logic [AddrW-1:0]           addr;
  logic [tpfa_pkg::CoefW-1:0] wdata, out_value_q;
  logic [tpfa_pkg::ResIdxW-1:0] out_ridx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      modulus_q <= tpfa_pkg::ModulusRst;
      center_q  <= tpfa_pkg::CenterRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        tpfa_pkg::CfgModulus: modulus_q <= cfg_data_i[tpfa_pkg::ModW-1:0];
        tpfa_pkg::CfgCenter:  center_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign cen_v = (center_q && coefficient_i >
                  tpfa_pkg::CoefW'(modulus_q >> 1))
                 ? coefficient_i - tpfa_pkg::CoefW'(modulus_q) : coefficient_i;

  assign ix = XW'(index_i);

  always_comb begin
    a_d     = ix;
    b_d     = ix - N;
    two_d   = 1'b0;
    sub_a_d = 1'b0;
    act_d   = 1'b0;
    if (opcode_i == tpfa_pkg::OpRead) begin
      act_d = (ix < N);
    end else if (ix < N) begin
      act_d = 1'b1;
    end else if (ix < NH) begin
      // x^N = x^H - 1: add at i-H, subtract at i-N
      a_d   = ix - H;
      two_d = 1'b1;
      act_d = 1'b1;
    end else if (ix <= TopI) begin
      // x^(3H) = -1
      a_d     = ix - NH;
      sub_a_d = 1'b1;
      act_d   = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.item_load) begin
      read_q   <= (opcode_i == tpfa_pkg::OpRead);
      two_q    <= two_d && (opcode_i == tpfa_pkg::OpLoad);
      sub_a_q  <= sub_a_d;
      addr_a_q <= a_d[AddrW-1:0];
      addr_b_q <= b_d[AddrW-1:0];
      val_q    <= cen_v;
      ridx_q   <= index_i[tpfa_pkg::ResIdxW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) clr_cnt_q <= '0;
    else if (cmd_i.clr_wr) clr_cnt_q <= clr_cnt_q + 1'b1;
  end

  always_comb begin
    if (cmd_i.clr_wr) addr = clr_cnt_q;
    else if (cmd_i.sel_b) addr = addr_b_q;
    else addr = addr_a_q;
  end

  always_comb begin
    if (cmd_i.clr_wr || read_q) wdata = '0;
    else if (cmd_i.sel_b || sub_a_q) wdata = rdata_q - val_q;
    else wdata = rdata_q + val_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mem_wr || cmd_i.clr_wr) mem[addr] <= wdata;
    if (cmd_i.mem_rd) rdata_q <= mem[addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_value_q <= rdata_q;
      out_ridx_q  <= ridx_q;
    end
  end

  assign status_o.in_act   = act_d;
  assign status_o.two      = two_q;
  assign status_o.is_read  = read_q;
  assign status_o.clr_last = (clr_cnt_q == AddrW'(DEGREE - 1));

  assign value_o        = out_value_q;
  assign result_index_o = out_ridx_q;

endmodule

// ===== hw/rtl/trinomial_poly_fold_accumulate_unit.sv =====
// Top level of the fold accumulator: reduces a polynomial product modulo
// x^DEGREE - x^(DEGREE/2) + 1. Depends on tpfa_pkg, tpfa_ctrl, tpfa_datapath.
//
//   channel | signals                                         | dir
//   --------+-------------------------------------------------+----
//   in      | in_valid_i, in_stall_o, opcode_i, index_i,      | in
//           | coefficient_i                                   |
//   out     | out_valid_o, out_stall_i, value_o,              | out
//           | result_index_o                                  |
//   cfg     | cfg_we_i, cfg_index_i, cfg_data_i               | in
//
// A read or a one-entry load uses one read-modify-write slot (SRdA, SWrA), a
// load that folds into two entries uses two (SRdA, SWrA, SRdB, SWrB) on the
// single memory port, and an item that touches nothing enters no slot.
// Reset starts a clearing pass that zeroes all DEGREE entries of the store; no
// input transfer is taken meanwhile, config writes are.
// A read waits in its write slot while an earlier result is still stalled.
module trinomial_poly_fold_accumulate_unit #(
  parameter int unsigned DEGREE = 1152
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [tpfa_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [tpfa_pkg::CfgW-1:0]           cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                opcode_i,
  input  logic [tpfa_pkg::IdxW-1:0]           index_i,
  input  logic [tpfa_pkg::CoefW-1:0]          coefficient_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [tpfa_pkg::CoefW-1:0]   value_o,
  output logic [tpfa_pkg::ResIdxW-1:0]        result_index_o
);

  tpfa_pkg::cmd_t             cmd;
  tpfa_pkg::status_t          status;
  logic [tpfa_pkg::CoefW-1:0] value;

  tpfa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  tpfa_datapath #(
    .DEGREE (DEGREE)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .opcode_i       (opcode_i),
    .index_i        (index_i),
    .coefficient_i  (coefficient_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .value_o        (value),
    .result_index_o (result_index_o)
  );

  assign value_o = $signed(value);

endmodule
